>>> src/pip_pkg.sv
// Shared types and constants for the point-in-polygon crossing test.
// Holds request codes, state encoding, register indexes and the test unit status.
// Used by every other file of the block; depends on nothing.
package pip_pkg;

    localparam int FIELD_W        = 12;
    localparam int OUT_CNT_W      = 8;
    localparam int REQ_W          = 2;
    localparam int CFG_IDX_W      = 1;
    localparam int MAX_EDGES_DEF  = 128;
    localparam int COORD_BITS_DEF = 12;

    localparam logic [FIELD_W-1:0] RAY_END_RESET = 12'd2000;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR  = 2'd0,
        REQ_APPEND = 2'd1,
        REQ_QUERY  = 2'd2
    } t_req;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RAY_END_X = 1'b0,
        CFG_RAY_END_Y = 1'b1
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } t_state;

    // Status of the crossing test pipeline as seen by the controller.
    typedef struct packed {
        logic vld;
        logic hit;
        logic busy;
    } t_test_out;

endpackage

>>> src/pip_in_if.sv
// Request channel of the point-in-polygon crossing test.
// Carries valid, ready and the request payload; depends on pip_pkg.
interface pip_in_if import pip_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [REQ_W-1:0]   req_type;
    logic [FIELD_W-1:0] x_a;
    logic [FIELD_W-1:0] y_a;
    logic [FIELD_W-1:0] x_b;
    logic [FIELD_W-1:0] y_b;

    modport source (output valid, req_type, x_a, y_a, x_b, y_b, input ready);
    modport sink   (input valid, req_type, x_a, y_a, x_b, y_b, output ready);
endinterface

>>> src/pip_out_if.sv
// Result channel of the point-in-polygon crossing test.
// Carries valid, ready and the result payload; depends on pip_pkg.
interface pip_out_if import pip_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 inside_res;
    logic [OUT_CNT_W-1:0] crossings;
    logic                 store_full;
    logic [OUT_CNT_W-1:0] edge_total;

    modport source (output valid, inside_res, crossings, store_full, edge_total, input ready);
    modport sink   (input valid, inside_res, crossings, store_full, edge_total, output ready);
endinterface

>>> src/point_in_polygon_crossing_test.sv
// Point-in-polygon test by ray-crossing parity over a ring of edge cells.
// Clear, append and unused requests return their result one cycle after the transaction.
// A query turns the ring once past the single crossing-test unit, waits for the test pipeline
// to empty and the output register to be free, then posts its result; the next request can be
// taken in the cycle that this result appears if the result is taken then.
// Synchronous active-low reset empties the edge list and loads 2000 into both ray ends.
module point_in_polygon_crossing_test import pip_pkg::*; #(
    parameter int MAX_EDGES  = MAX_EDGES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [FIELD_W-1:0]   i_cfg_data,
    pip_in_if.sink               i_in,
    pip_out_if.source            o_out
);

    // CW holds an edge count up to MAX_EDGES, SW indexes one turn of the ring.
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int SW = $clog2(MAX_EDGES);
    localparam int EW = 4 * COORD_BITS;

    // The edge store is a ring of cells. Appends write the cell whose position equals
    // the current edge count. A query turns the ring once, so at step t the head cell
    // holds edge t, and only steps below the edge count feed the test unit. After a
    // full turn every edge is back in its own cell.
    logic [EW-1:0]         w_cell [MAX_EDGES];

    t_state                r_state, n_state;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [SW-1:0]         r_step, n_step;
    logic [CW-1:0]         r_cross, n_cross;
    logic [COORD_BITS-1:0] r_px, n_px;
    logic [COORD_BITS-1:0] r_py, n_py;
    logic [FIELD_W-1:0]    r_ray_x;
    logic [FIELD_W-1:0]    r_ray_y;

    logic                  r_ov;
    logic                  r_o_inside;
    logic [OUT_CNT_W-1:0]  r_o_cross;
    logic                  r_o_full;
    logic [OUT_CNT_W-1:0]  r_o_total;

    logic                  w_acc;
    logic                  w_out_free;
    logic                  w_full;
    logic                  w_append;
    logic                  w_feed;
    logic                  w_out_wr;
    logic                  w_o_inside;
    logic [OUT_CNT_W-1:0]  w_o_cross;
    logic                  w_o_full;
    logic [OUT_CNT_W-1:0]  w_o_total;
    logic [EW-1:0]         w_new_edge;
    t_test_out             w_st;

    assign w_out_free = !r_ov || o_out.ready;
    assign i_in.ready = (r_state == ST_IDLE) && w_out_free;
    assign w_acc      = i_in.valid && i_in.ready;
    assign w_full     = (r_cnt == CW'(MAX_EDGES));

    assign w_new_edge = {COORD_BITS'(i_in.x_a), COORD_BITS'(i_in.y_a),
                         COORD_BITS'(i_in.x_b), COORD_BITS'(i_in.y_b)};

    for (genvar k = 0; k < MAX_EDGES; k++) begin : g_cell
        pip_cell #(
            .W (EW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_load       (w_append && (r_cnt == CW'(k))),
            .i_load_data  (w_new_edge),
            .i_shift      (r_state == ST_RUN),
            .i_shift_data (w_cell[(k + 1) % MAX_EDGES]),
            .o_data       (w_cell[k])
        );
    end

    pip_test #(
        .COORD_BITS (COORD_BITS)
    ) u_test (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_feed),
        .i_edge  (w_cell[0]),
        .i_px    (r_px),
        .i_py    (r_py),
        .i_rx    (COORD_BITS'(r_ray_x)),
        .i_ry    (COORD_BITS'(r_ray_y)),
        .o_st    (w_st)
    );

    // Configuration registers; writes must only arrive while the block is idle, which the block does not enforce.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ray_x <= RAY_END_RESET;
            r_ray_y <= RAY_END_RESET;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_RAY_END_X: r_ray_x <= i_cfg_data;
                CFG_RAY_END_Y: r_ray_y <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_step  <= '0;
            r_cross <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_step  <= n_step;
            r_cross <= n_cross;
        end
    end

    always_ff @(posedge i_clk) begin
        r_px <= n_px;
        r_py <= n_py;
    end

    // Controller: decodes requests when idle, turns the ring for a query, then waits for the test
    // pipeline to empty and the output register to be free before posting the query result.
    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_step     = r_step;
        n_cross    = r_cross;
        n_px       = r_px;
        n_py       = r_py;
        w_append   = 1'b0;
        w_feed     = 1'b0;
        w_out_wr   = 1'b0;
        w_o_inside = 1'b0;
        w_o_cross  = '0;
        w_o_full   = 1'b0;
        w_o_total  = OUT_CNT_W'(r_cnt);

        if (w_st.vld && w_st.hit) begin
            n_cross = r_cross + CW'(1);
        end

        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    unique case (t_req'(i_in.req_type))
                        REQ_CLEAR: begin
                            n_cnt     = '0;
                            w_out_wr  = 1'b1;
                            w_o_total = '0;
                        end
                        REQ_APPEND: begin
                            w_out_wr = 1'b1;
                            if (w_full) begin
                                w_o_full = 1'b1;
                            end else begin
                                w_append  = 1'b1;
                                n_cnt     = r_cnt + CW'(1);
                                w_o_total = OUT_CNT_W'(r_cnt + CW'(1));
                            end
                        end
                        REQ_QUERY: begin
                            n_px    = COORD_BITS'(i_in.x_a);
                            n_py    = COORD_BITS'(i_in.y_a);
                            n_cross = '0;
                            n_step  = '0;
                            n_state = ST_RUN;
                        end
                        default: begin
                            w_out_wr = 1'b1;
                        end
                    endcase
                end
            end
            ST_RUN: begin
                w_feed = (CW'(r_step) < r_cnt);
                n_step = r_step + SW'(1);
                if (r_step == SW'(MAX_EDGES - 1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!w_st.busy && w_out_free) begin
                    w_out_wr   = 1'b1;
                    w_o_inside = r_cross[0];
                    w_o_cross  = OUT_CNT_W'(r_cross);
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Output register: holds a result until its transaction completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_out_wr) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_wr) begin
            r_o_inside <= w_o_inside;
            r_o_cross  <= w_o_cross;
            r_o_full   <= w_o_full;
            r_o_total  <= w_o_total;
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.inside_res = r_o_inside;
    assign o_out.crossings  = r_o_cross;
    assign o_out.store_full = r_o_full;
    assign o_out.edge_total = r_o_total;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_EDGES))
        else $error("edge count above store depth");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !w_st.busy)
        else $error("crossing test busy while idle");

    a_cross_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> (r_cross <= r_cnt))
        else $error("more crossings than stored edges");

    a_run_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_step == SW'(MAX_EDGES - 1)) |=> (r_state == ST_DRAIN))
        else $error("ring turn did not end after one revolution");
`endif

endmodule

>>> src/pip_cell.sv
// One cell of the edge ring: holds a single polygon edge.
// Loads a new edge on append and passes its edge to its neighbor while the ring turns.
module pip_cell import pip_pkg::*; #(
    parameter int W = 4 * COORD_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_load,
    input  logic [W-1:0] i_load_data,
    input  logic         i_shift,
    input  logic [W-1:0] i_shift_data,
    output logic [W-1:0] o_data
);

    logic [W-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_load_data;
        end else if (i_shift) begin
            r_data <= i_shift_data;
        end
    end

    assign o_data = r_data;

endmodule

>>> src/pip_test.sv
// Two-stage crossing test of one edge against the query segment.
// Stage one registers eight cross-product terms, stage two the crossing decision.
// Depends on pip_pkg for the status struct.
module pip_test import pip_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  logic [4*COORD_BITS-1:0] i_edge,
    input  logic [COORD_BITS-1:0]   i_px,
    input  logic [COORD_BITS-1:0]   i_py,
    input  logic [COORD_BITS-1:0]   i_rx,
    input  logic [COORD_BITS-1:0]   i_ry,
    output t_test_out               o_st
);

    localparam int D = COORD_BITS + 1;
    localparam int P = 2 * D;

    logic [COORD_BITS-1:0] w_ax, w_ay, w_bx, w_by;
    logic signed [D-1:0]   w_ebx, w_eby, w_p0x, w_p0y, w_p1x, w_p1y;
    logic signed [D-1:0]   w_sx, w_sy, w_qax, w_qay, w_qbx, w_qby;
    logic signed [P-1:0]   w_m [8];
    logic signed [P-1:0]   r_m [8];
    logic                  r_va;
    logic [P:0]            w_v [4];
    logic [3:0]            w_neg;
    logic [3:0]            w_zero;
    logic                  w_hit;
    logic                  r_hit;
    logic                  r_vb;

    function automatic logic signed [D-1:0] diff(input logic [COORD_BITS-1:0] a,
                                                 input logic [COORD_BITS-1:0] b);
        diff = $signed({1'b0, a}) - $signed({1'b0, b});
    endfunction

    assign {w_ax, w_ay, w_bx, w_by} = i_edge;

    always_comb begin
        // Edge direction and point offsets from the edge start.
        w_ebx = diff(w_bx, w_ax);
        w_eby = diff(w_by, w_ay);
        w_p0x = diff(i_px, w_ax);
        w_p0y = diff(i_py, w_ay);
        w_p1x = diff(i_rx, w_ax);
        w_p1y = diff(i_ry, w_ay);
        // Segment direction and edge endpoint offsets from the query point.
        w_sx  = diff(i_rx, i_px);
        w_sy  = diff(i_ry, i_py);
        w_qax = diff(w_ax, i_px);
        w_qay = diff(w_ay, i_py);
        w_qbx = diff(w_bx, i_px);
        w_qby = diff(w_by, i_py);

        w_m[0] = w_ebx * w_p0y;
        w_m[1] = w_eby * w_p0x;
        w_m[2] = w_ebx * w_p1y;
        w_m[3] = w_eby * w_p1x;
        w_m[4] = w_sx * w_qay;
        w_m[5] = w_sy * w_qax;
        w_m[6] = w_sx * w_qby;
        w_m[7] = w_sy * w_qbx;
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 8; k++) begin
            r_m[k] <= w_m[k];
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_v[k]    = {r_m[2*k][P-1], r_m[2*k]} - {r_m[2*k+1][P-1], r_m[2*k+1]};
            w_neg[k]  = w_v[k][P];
            w_zero[k] = (w_v[k] == '0);
        end
        // A sign product is at most zero when either side is zero or the signs differ.
        w_hit = (w_zero[0] || w_zero[1] || (w_neg[0] != w_neg[1]))
             && (w_zero[2] || w_zero[3] || (w_neg[2] != w_neg[3]));
    end

    always_ff @(posedge i_clk) begin
        r_hit <= w_hit;
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_vld;
            r_vb <= r_va;
        end
    end

    assign o_st.vld  = r_vb;
    assign o_st.hit  = r_hit;
    assign o_st.busy = r_va || r_vb;

endmodule

>>> tb/tb_point_in_polygon_crossing_test.sv
// Self-checking testbench for the point-in-polygon crossing test block.
// Needs pip_pkg, pip_in_if, pip_out_if, pip_cell, pip_test and point_in_polygon_crossing_test from src.
// Predicts every result from its own copy of the edge list and compares in order.
`timescale 1ns / 100ps

module tb_point_in_polygon_crossing_test;
    import pip_pkg::*;

    // The block is built with its default sizes, so the predictor uses the same ones.
    localparam int MAX_EDGES     = MAX_EDGES_DEF;
    localparam int CYCLE_LIMIT   = 800000;
    localparam int HOLD_AT       = 60;     // transactions taken before the long output stall
    localparam int HOLD_CYCLES   = 400;
    localparam int RAY_SETTINGS  = 6;
    localparam int ROUNDS        = 13;     // polygon rounds per ray setting
    localparam int CALM_SETTING  = 3;      // ray setting that runs with no idling at all
    localparam int FILL_SETTING  = 2;      // ray setting that also overfills the store

    // Request code 3 has no meaning in the block; it must come back as a plain status.
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic [FIELD_W-1:0] xa;
        logic [FIELD_W-1:0] ya;
        logic [FIELD_W-1:0] xb;
        logic [FIELD_W-1:0] yb;
    } t_pip_request;

    typedef struct packed {
        logic                 in_poly;
        logic [OUT_CNT_W-1:0] crossings;
        logic                 refused;
        logic [OUT_CNT_W-1:0] held;
    } t_pip_answer;

    typedef struct packed {
        logic [FIELD_W-1:0] ax;
        logic [FIELD_W-1:0] ay;
        logic [FIELD_W-1:0] bx;
        logic [FIELD_W-1:0] by;
    } t_stored_seg;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [FIELD_W-1:0]   cfg_data;

    pip_in_if  in_ch ();
    pip_out_if out_ch ();

    point_in_polygon_crossing_test u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    // Predictor state: the testbench's own copy of the edge list and the ray end.
    t_stored_seg        seg_copy [MAX_EDGES];
    int                 held_count = 0;
    logic [FIELD_W-1:0] ray_x = RAY_END_RESET;
    logic [FIELD_W-1:0] ray_y = RAY_END_RESET;

    t_pip_request pending_requests [$];   // filled by the stimulus, drained by the driver
    t_pip_answer  expected_answers [$];   // one entry per accepted transaction
    t_pip_request offered;                // the request currently on the input channel

    bit          calm_mode = 1'b0;
    int unsigned cycle_count = 0;
    int          taken_count = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;
    int          mismatch_count = 0;
    int          planned_count = 0;
    int          checked_count = 0;
    int          n_query = 0;
    int          n_append = 0;
    int          n_refused = 0;
    int          n_clear = 0;
    int          n_unused = 0;
    int          most_crossings = 0;
    int          deepest_store = 0;

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Sign of the cross product (b - o) x (p - o). With 12-bit coordinates the
    // products stay far below the range of a 32-bit int, so the sign is exact.
    function automatic int crossing_sign(int ox, int oy, int bx, int by, int px, int py);
        int v;
        v = (bx - ox) * (py - oy) - (by - oy) * (px - ox);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // The query segment p0-p1 meets the edge when each segment has the ends of the
    // other on opposite sides or on its line. Touching and collinear overlap count.
    function automatic bit segments_meet(int p0x, int p0y, int p1x, int p1y, t_stored_seg s);
        int ax, ay, bx, by;
        int s1, s2, s3, s4;
        ax = int'(s.ax);
        ay = int'(s.ay);
        bx = int'(s.bx);
        by = int'(s.by);
        s1 = crossing_sign(ax, ay, bx, by, p0x, p0y);
        s2 = crossing_sign(ax, ay, bx, by, p1x, p1y);
        s3 = crossing_sign(p0x, p0y, p1x, p1y, ax, ay);
        s4 = crossing_sign(p0x, p0y, p1x, p1y, bx, by);
        return (s1 * s2 <= 0) && (s3 * s4 <= 0);
    endfunction

    // Applies one accepted request to the predictor state and returns its answer.
    function automatic t_pip_answer polygon_answer(t_pip_request r);
        t_pip_answer a;
        int          n;
        int          i;
        a = '0;
        case (r.req)
            REQ_CLEAR: begin
                held_count = 0;
                n_clear++;
            end
            REQ_APPEND: begin
                n_append++;
                if (held_count >= MAX_EDGES) begin
                    // A full store drops the edge and flags the refusal.
                    a.refused = 1'b1;
                    n_refused++;
                end else begin
                    seg_copy[held_count] = '{r.xa, r.ya, r.xb, r.yb};
                    held_count++;
                end
            end
            REQ_QUERY: begin
                n = 0;
                for (i = 0; i < held_count; i++) begin
                    if (segments_meet(int'(r.xa), int'(r.ya), int'(ray_x), int'(ray_y),
                                      seg_copy[i]))
                        n++;
                end
                a.crossings = n[OUT_CNT_W-1:0];
                a.in_poly   = n[0];
                n_query++;
                if (n > most_crossings) most_crossings = n;
            end
            default: begin
                n_unused++;
            end
        endcase
        a.held = held_count[OUT_CNT_W-1:0];
        if (held_count > deepest_store) deepest_store = held_count;
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // Compares the result on the output channel with the oldest expectation.
    task automatic check_answer();
        t_pip_answer want;
        if (expected_answers.size() == 0) begin
            report_mismatch($sformatf("result with nothing pending (crossings %0d, held %0d)",
                                      out_ch.crossings, out_ch.edge_total));
            return;
        end
        want = expected_answers.pop_front();
        checked_count++;
        if (out_ch.inside_res !== want.in_poly)
            report_mismatch($sformatf("inside_res %b, expected %b (result %0d)",
                                      out_ch.inside_res, want.in_poly, checked_count));
        if (out_ch.crossings !== want.crossings)
            report_mismatch($sformatf("crossings %0d, expected %0d (result %0d)",
                                      out_ch.crossings, want.crossings, checked_count));
        if (out_ch.store_full !== want.refused)
            report_mismatch($sformatf("store_full %b, expected %b (result %0d)",
                                      out_ch.store_full, want.refused, checked_count));
        if (out_ch.edge_total !== want.held)
            report_mismatch($sformatf("edge_total %0d, expected %0d (result %0d)",
                                      out_ch.edge_total, want.held, checked_count));
    endtask

    // ------------------------------------------------------------------
    // Driver: presents pending requests, holds each one until it is taken,
    // and runs the predictor at the edge of acceptance so that the order of
    // expectations follows the order of transactions.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_answers.push_back(polygon_answer(offered));
                taken_count <= taken_count + 1;
            end
            if (!in_ch.valid || in_ch.ready) begin
                // About one cycle in five is left idle unless the calm phase runs.
                if (pending_requests.size() != 0 && (calm_mode || $urandom_range(99) >= 20)) begin
                    offered = pending_requests.pop_front();
                    in_ch.valid    <= 1'b1;
                    in_ch.req_type <= offered.req;
                    in_ch.x_a      <= offered.xa;
                    in_ch.y_a      <= offered.ya;
                    in_ch.x_b      <= offered.xb;
                    in_ch.y_b      <= offered.yb;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: takes results, checks them, and throttles ready. Once, after
    // HOLD_AT transactions, it refuses results for a long stretch while the
    // driver keeps offering, so the block has to back up into its input.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready)
                check_answer();
            if (hold_left != 0) begin
                hold_left    <= hold_left - 1;
                out_ch.ready <= 1'b0;
            end else if (!hold_done && taken_count >= HOLD_AT) begin
                hold_left    <= HOLD_CYCLES;
                hold_done    <= 1'b1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= calm_mode || ($urandom_range(99) >= 20);
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, expected_answers.size());
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void push_request(logic [REQ_W-1:0] req, int xa, int ya, int xb, int yb);
        t_pip_request r;
        r.req = req;
        r.xa  = xa[FIELD_W-1:0];
        r.ya  = ya[FIELD_W-1:0];
        r.xb  = xb[FIELD_W-1:0];
        r.yb  = yb[FIELD_W-1:0];
        pending_requests.push_back(r);
        planned_count++;
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(4095));
    endfunction

    // Writes one ray end register. Only called while the block is idle.
    task automatic set_ray_end(t_cfg_idx idx, logic [FIELD_W-1:0] value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == CFG_RAY_END_X) ray_x = value;
        else ray_y = value;
        @(negedge i_clk);
    endtask

    // Sender pause: nothing more is offered until every expected result is back.
    task automatic wait_for_drain();
        while (pending_requests.size() != 0 || in_ch.valid || expected_answers.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Hand-picked cases, run with the ray end still at its reset value of 2000, 2000.
    task automatic queue_directed();
        push_request(REQ_QUERY, 0, 0, 4095, 4095);           // query on an empty store
        push_request(REQ_UNUSED, 4095, 4095, 4095, 4095);    // unused code, all ones
        push_request(REQ_APPEND, 0, 0, 4095, 4095);          // corner to corner diagonals
        push_request(REQ_APPEND, 4095, 0, 0, 4095);
        push_request(REQ_APPEND, 2000, 2000, 2000, 2000);    // single point at the ray end
        push_request(REQ_APPEND, 500, 500, 1000, 1000);      // lies on the line y = x
        push_request(REQ_APPEND, 3000, 100, 3000, 100);      // single point off the ray
        push_request(REQ_QUERY, 0, 0, 0, 0);                 // collinear with every edge on the line y = x
        push_request(REQ_QUERY, 4095, 4095, 0, 0);
        push_request(REQ_QUERY, 0, 4095, 4095, 0);
        push_request(REQ_QUERY, 4095, 0, 0, 4095);
        push_request(REQ_QUERY, 2000, 2000, 0, 0);           // query point equals the ray end
        push_request(REQ_QUERY, 3000, 100, 0, 0);            // starts on the single-point edge
        push_request(REQ_QUERY, 2047, 2048, 4095, 4095);
        push_request(REQ_CLEAR, 4095, 4095, 4095, 4095);
        push_request(REQ_QUERY, 100, 100, 0, 0);             // nothing left to cross
        push_request(REQ_APPEND, 100, 100, 300, 100);        // a small square
        push_request(REQ_APPEND, 300, 100, 300, 300);
        push_request(REQ_APPEND, 300, 300, 100, 300);
        push_request(REQ_APPEND, 100, 300, 100, 100);
        push_request(REQ_QUERY, 200, 200, 0, 0);             // inside
        push_request(REQ_QUERY, 100, 200, 0, 0);             // on an edge
        push_request(REQ_QUERY, 300, 300, 0, 0);             // on a vertex
        push_request(REQ_QUERY, 50, 50, 0, 0);               // outside
        push_request(REQ_UNUSED, 0, 0, 0, 0);
    endtask

    // One well-formed round: usually a clear, a closed polygon, then queries around it.
    // A few items in each round are noise of any request code.
    task automatic queue_polygon_round();
        int n, nq, k, j, pick;
        int cx, cy, rad;
        int vx [10];
        int vy [10];
        n   = $urandom_range(3, 10);
        nq  = $urandom_range(6, 12);
        // Mostly local shapes; one in four spans nearly the whole coordinate range.
        rad = ($urandom_range(3) == 0) ? 2047 : int'($urandom_range(2, 400));
        cx  = int'($urandom_range(rad, 4095 - rad));
        cy  = int'($urandom_range(rad, 4095 - rad));
        for (k = 0; k < n; k++) begin
            vx[k] = cx - rad + int'($urandom_range(2 * rad));
            vy[k] = cy - rad + int'($urandom_range(2 * rad));
        end
        if ($urandom_range(9) != 0)
            push_request(REQ_CLEAR, any_coord(), any_coord(), any_coord(), any_coord());
        for (k = 0; k < n; k++) begin
            j = (k + 1) % n;
            push_request(REQ_APPEND, vx[k], vy[k], vx[j], vy[j]);
        end
        for (k = 0; k < nq; k++) begin
            pick = $urandom_range(9);
            j    = $urandom_range(n - 1);
            case (pick)
                0, 1, 2, 3:
                    push_request(REQ_QUERY, cx - rad + int'($urandom_range(2 * rad)),
                                 cy - rad + int'($urandom_range(2 * rad)),
                                 any_coord(), any_coord());
                4, 5:
                    push_request(REQ_QUERY, any_coord(), any_coord(), any_coord(), any_coord());
                6:
                    push_request(REQ_QUERY, vx[j], vy[j], any_coord(), any_coord());
                7:  // near the middle of an edge, sometimes exactly on it
                    push_request(REQ_QUERY, (vx[j] + vx[(j + 1) % n]) / 2,
                                 (vy[j] + vy[(j + 1) % n]) / 2, any_coord(), any_coord());
                8:
                    push_request(REQ_QUERY, int'(ray_x), int'(ray_y), any_coord(), any_coord());
                default:
                    push_request(REQ_W'($urandom_range(3)), any_coord(), any_coord(),
                                 any_coord(), any_coord());
            endcase
        end
    endtask

    // Fills the store past its capacity with random edges, queries along the way,
    // and checks that extra appends are refused and the count stays at the limit.
    task automatic queue_overflow();
        int k;
        push_request(REQ_CLEAR, 0, 0, 0, 0);
        for (k = 0; k < MAX_EDGES + 4; k++) begin
            push_request(REQ_APPEND, any_coord(), any_coord(), any_coord(), any_coord());
            if (k % 40 == 39)
                push_request(REQ_QUERY, any_coord(), any_coord(), any_coord(), any_coord());
        end
        for (k = 0; k < 3; k++)
            push_request(REQ_QUERY, any_coord(), any_coord(), any_coord(), any_coord());
        push_request(REQ_APPEND, 4095, 4095, 4095, 4095);
        push_request(REQ_UNUSED, any_coord(), any_coord(), any_coord(), any_coord());
        push_request(REQ_CLEAR, 0, 0, 0, 0);
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        int s, k;
        logic [FIELD_W-1:0] end_x [RAY_SETTINGS];
        logic [FIELD_W-1:0] end_y [RAY_SETTINGS];

        // Ray ends to visit: the four corners of the range, then arbitrary points.
        end_x = '{12'd4095, 12'd0, 12'd0, 12'd4095, 12'd0, 12'd1234};
        end_y = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd3071};
        end_x[4] = FIELD_W'($urandom_range(4095));
        end_y[4] = FIELD_W'($urandom_range(4095));

        // The channel signals are owned by the driver and the monitor, which clear
        // their valid and ready while reset is held.
        i_rst_n        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_idx        <= CFG_RAY_END_X;
        cfg_data       <= '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // The directed part relies on the reset value of both ray ends.
        queue_directed();
        wait_for_drain();

        for (s = 0; s < RAY_SETTINGS; s++) begin
            set_ray_end(CFG_RAY_END_X, end_x[s]);
            set_ray_end(CFG_RAY_END_Y, end_y[s]);
            calm_mode = (s == CALM_SETTING);
            if (s == FILL_SETTING)
                queue_overflow();
            for (k = 0; k < ROUNDS; k++)
                queue_polygon_round();
            wait_for_drain();
        end
        calm_mode = 1'b0;

        // A query is the slowest item; give any stray result time to show up.
        repeat (MAX_EDGES + 8) @(posedge i_clk);
        if (expected_answers.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived",
                                      expected_answers.size()));

        $display("covered %0d transactions: %0d queries, %0d appends (%0d refused), %0d clears,",
                 planned_count, n_query, n_append, n_refused, n_clear);
        $display("%0d unused codes, %0d ray end settings, up to %0d edges and %0d crossings",
                 n_unused, RAY_SETTINGS + 1, deepest_store, most_crossings);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
